// ----- rtl/mi3_pkg.sv -----
package mi3_pkg;

	localparam int unsigned ELEM_WIDTH_D = 32;
	localparam int unsigned FRAC_BITS_D = 16;
	localparam int unsigned N_ELEM = 9;

	typedef logic [3:0] elem_idx_t;

	// cofactor k = a[p]*a[q] - a[s]*a[t], columns p q s t
	localparam elem_idx_t COF_IDX [N_ELEM][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd1, 4'd6, 4'd0, 4'd7},
		'{4'd0, 4'd4, 4'd1, 4'd3}
	};

	// diagonal positions of a row-major 3x3 result
	localparam logic [N_ELEM-1:0] DIAG_MASK = 9'b100010001;

endpackage

// ----- rtl/matrix3_inverse.sv -----
// Streaming 3x3 inverse of signed fixed-point matrices by the adjugate method. One matrix
// enters per cycle on the s_ side unless backpressure stalls it, and its inverse leaves on the m_ side:
// six stages form the cofactors and the exact determinant, then W+1 divider stages, an
// overflow check and then one quotient bit per stage for all nine elements in parallel,
// lead to a last stage that saturates and registers the result. Backpressure
// stalls only the stages that hold data, so bubbles are squeezed out. A determinant whose
// magnitude in element format is below det_epsilon gives the identity with the singular flag.
module matrix3_inverse #(
	parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_D,
	parameter int unsigned FRAC_BITS = mi3_pkg::FRAC_BITS_D
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [30:0] cfg_data,  // det_epsilon
	input  logic s_tvalid,
	output logic s_tready,
	// a00 a01 a02 a10 a11 a12 a20 a21 a22, zero padded
	input  logic [((mi3_pkg::N_ELEM*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// r00 r01 r02 r10 r11 r12 r20 r21 r22, zero padded
	output logic [((mi3_pkg::N_ELEM*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic [1:0] m_tuser  // singular, saturated
);
	import mi3_pkg::*;

	localparam int unsigned W = ELEM_WIDTH;
	localparam int unsigned F = FRAC_BITS;
	localparam int unsigned TW = ((N_ELEM*W+7)/8)*8;
	localparam int unsigned PW = 2*W;
	localparam int unsigned CW = 2*W+1;
	localparam int unsigned HW = 2*W+1;
	localparam int unsigned DW = 3*W+3;
	localparam int unsigned XW = ((CW+2*F) > (DW+W) ? (CW+2*F) : (DW+W)) + 1;
	localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE_V = (F > W-2) ? MAXPOS : (W'(1) << F);

	logic [30:0] det_epsilon_q;

	logic signed [W-1:0] a_in [N_ELEM];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	logic signed [PW-1:0] p0_s1 [N_ELEM];
	logic signed [PW-1:0] p1_s1 [N_ELEM];
	logic signed [W-1:0] a_s1 [3];
	logic signed [CW-1:0] c_s2 [N_ELEM];
	logic signed [W-1:0] a_s2 [3];
	logic signed [HW-1:0] ph_s3 [3];
	logic signed [HW-1:0] pl_s3 [3];
	logic signed [CW-1:0] c_s3 [N_ELEM];
	logic signed [DW-1:0] t_s4 [3];
	logic signed [CW-1:0] c_s4 [N_ELEM];
	logic signed [DW-1:0] det_s5;
	logic signed [CW-1:0] c_s5 [N_ELEM];
	logic [DW-1:0] mag_s6;
	logic sing_s6;
	logic [XW-1:0] num_s6 [N_ELEM];
	logic [N_ELEM-1:0] neg_s6;

	logic v_d [W+1];
	logic en_d [W+1];
	logic [XW-1:0] rem_d [W+1][N_ELEM];
	logic [W-1:0] q_d [W+1][N_ELEM];
	logic [N_ELEM-1:0] ovf_d [W+1];
	logic [N_ELEM-1:0] neg_d [W+1];
	logic [DW-1:0] mag_d [W+1];
	logic sing_d [W+1];

	logic [W-1:0] r_s7 [N_ELEM];
	logic sing_s7, sat_s7;

	logic [DW-1:0] mag_c;
	logic [W-1:0] r_c [N_ELEM];
	logic [N_ELEM-1:0] sat_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_epsilon_q <= 31'd1;
		end else if (cfg_valid && cfg_ready) begin
			det_epsilon_q <= cfg_data;
		end
	end

	assign en_s7 = !v_s7 || m_tready;
	assign en_d[W] = !v_d[W] || en_s7;
	for (genvar j = 0; j < W; j++) begin : g_en
		assign en_d[j] = !v_d[j] || en_d[j+1];
	end
	assign en_s6 = !v_s6 || en_d[0];
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_d[W];
		end
	end

	always_comb begin
		for (int i = 0; i < N_ELEM; i++) begin
			a_in[i] = $signed(s_tdata[i*W +: W]);
		end
	end

	// products of the cofactors
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < N_ELEM; i++) begin
				p0_s1[i] <= a_in[COF_IDX[i][0]] * a_in[COF_IDX[i][1]];
				p1_s1[i] <= a_in[COF_IDX[i][2]] * a_in[COF_IDX[i][3]];
			end
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= a_in[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int i = 0; i < N_ELEM; i++) begin
				c_s2[i] <= CW'(p0_s1[i]) - CW'(p1_s1[i]);
			end
			a_s2 <= a_s1;
		end
	end

	// determinant partial products, cofactor split into high and low halves
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int k = 0; k < 3; k++) begin
				ph_s3[k] <= a_s2[k] * $signed(c_s2[3*k][CW-1:W]);
				pl_s3[k] <= a_s2[k] * $signed({1'b0, c_s2[3*k][W-1:0]});
			end
			c_s3 <= c_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int k = 0; k < 3; k++) begin
				t_s4[k] <= (DW'(ph_s3[k]) <<< W) + DW'(pl_s3[k]);
			end
			c_s4 <= c_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			det_s5 <= t_s4[0] + t_s4[1] + t_s4[2];
			c_s5 <= c_s4;
		end
	end

	assign mag_c = det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			mag_s6 <= mag_c;
			sing_s6 <= (mag_c == '0) || ((mag_c >> (2*F)) < DW'(det_epsilon_q));
			for (int i = 0; i < N_ELEM; i++) begin
				num_s6[i] <= (c_s5[i][CW-1] ? XW'(-c_s5[i]) & XW'({CW{1'b1}})
					: XW'(c_s5[i])) << (2*F);
				neg_s6[i] <= c_s5[i][CW-1] ^ det_s5[DW-1];
			end
		end
	end

	// divider entry: quotient overflow check against mag << W
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (en_d[0]) begin
			v_d[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_d[0]) begin
			for (int i = 0; i < N_ELEM; i++) begin
				rem_d[0][i] <= num_s6[i];
				q_d[0][i] <= '0;
				ovf_d[0][i] <= num_s6[i] >= (XW'(mag_s6) << W);
			end
			neg_d[0] <= neg_s6;
			mag_d[0] <= mag_s6;
			sing_d[0] <= sing_s6;
		end
	end

	for (genvar j = 1; j <= W; j++) begin : g_div
		logic [XW-1:0] sh;
		logic [N_ELEM-1:0] ge;

		assign sh = XW'(mag_d[j-1]) << (W-j);
		always_comb begin
			for (int i = 0; i < N_ELEM; i++) begin
				ge[i] = rem_d[j-1][i] >= sh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[j] <= 1'b0;
			end else if (en_d[j]) begin
				v_d[j] <= v_d[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_d[j]) begin
				for (int i = 0; i < N_ELEM; i++) begin
					rem_d[j][i] <= ge[i] ? rem_d[j-1][i] - sh : rem_d[j-1][i];
					q_d[j][i] <= {q_d[j-1][i][W-2:0], ge[i]};
				end
				ovf_d[j] <= ovf_d[j-1];
				neg_d[j] <= neg_d[j-1];
				mag_d[j] <= mag_d[j-1];
				sing_d[j] <= sing_d[j-1];
			end
		end
	end

	// saturate and sign
	always_comb begin
		logic [W-1:0] lim;
		logic [W-1:0] val;
		for (int i = 0; i < N_ELEM; i++) begin
			lim = neg_d[W][i] ? MINNEG : MAXPOS;
			sat_c[i] = ovf_d[W][i] || (q_d[W][i] > lim);
			val = sat_c[i] ? lim : q_d[W][i];
			r_c[i] = neg_d[W][i] ? -val : val;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			for (int i = 0; i < N_ELEM; i++) begin
				r_s7[i] <= sing_d[W] ? (DIAG_MASK[i] ? ONE_V : '0) : r_c[i];
			end
			sing_s7 <= sing_d[W];
			sat_s7 <= !sing_d[W] && (|sat_c);
		end
	end

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < N_ELEM; i++) begin
			m_tdata[i*W +: W] = r_s7[i];
		end
	end

	assign m_tvalid = v_s7;
	assign m_tuser = {sat_s7, sing_s7};

endmodule

// ----- rtl/mi3_check.sv -----
module mi3_check #(
	parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_D
) (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((mi3_pkg::N_ELEM*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
	input logic [1:0] m_tuser
);
	import mi3_pkg::*;

	localparam int unsigned W = ELEM_WIDTH;

	logic offdiag_zero;

	always_comb begin
		offdiag_zero = 1'b1;
		for (int i = 0; i < N_ELEM; i++) begin
			if (!DIAG_MASK[i] && (m_tdata[i*W +: W] != '0)) offdiag_zero = 1'b0;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output transaction changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("singular and saturated both set");

	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> offdiag_zero && (m_tdata[W-1:0] != '0))
		else $error("singular result is not the identity");

endmodule

bind matrix3_inverse mi3_check #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_check (.*);
